/* hw/rtl/kci_pkg.sv */
// ----------------------------------------------------------------------------
// kci_pkg: shared types and constants for the keyframe color interpolator
// Keyframe entry layout, queue item, status codes and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package kci_pkg;

  localparam int MAX_KEYS    = 32;
  localparam int KEY_AW      = $clog2(MAX_KEYS);
  localparam int KEY_CW      = $clog2(MAX_KEYS + 1);
  localparam int TIME_W      = 15;
  localparam int COL_W       = 13;
  localparam int MOD_W       = 11;
  localparam int BMOD_W      = 12;
  localparam int SCALE_W     = 12;
  localparam int PH_W        = 13;
  localparam int STAT_W      = 3;
  localparam int SUM_W       = 26;
  localparam int PROD_W      = 35;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TIME_W-1:0]  DAY_END     = 15'd23040;
  localparam logic [COL_W-1:0]   ONE_Q12     = 13'd4096;
  localparam logic [BMOD_W-1:0]  BMOD_RESET  = 12'd256;
  localparam logic [BMOD_W-1:0]  BMOD_MAX    = 12'd4095;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_SINGLE   = 3'd3,
    STAT_BAD_ENDS = 3'd4,
    STAT_NO_SEG   = 3'd5
  } status_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [TIME_W-1:0] tod;
    rgb_t              color;
    logic [MOD_W-1:0]  band_mod;
    rgb_t              band;
  } key_entry_t;

  typedef struct packed {
    func_t      func;
    key_entry_t key;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_SGL_W,
    BK_SGL,
    BK_CHK0_W,
    BK_CHK0,
    BK_CHKN_W,
    BK_CHKN,
    BK_SCAN_W,
    BK_SCAN,
    BK_DIV_INIT,
    BK_DIV,
    BK_LERP,
    BK_STORE,
    BK_MODFIN
  } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/kci_queue.sv */
// ----------------------------------------------------------------------------
// kci_queue: short item queue between front and back
// Two-entry FIFO that lets the front take an item while the back is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module kci_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire kci_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output kci_pkg::item_t      head,
  output logic                empty
);
  import kci_pkg::*;

  item_t                slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]  count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kci_front.sv */
// ----------------------------------------------------------------------------
// kci_front: command intake
// Takes a command, saturates its time of day and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kci_front (
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [kci_pkg::TIME_W-1:0]    in_time_of_day,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_red,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_green,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_blue,
  input  wire logic [kci_pkg::MOD_W-1:0]     in_key_band_mod,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_band_red,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_band_green,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_band_blue,
  input  wire logic                          q_full,
  output logic                               q_push,
  output kci_pkg::item_t                     q_item
);
  import kci_pkg::*;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_item.func             = func_t'(in_func);
    // Times past the end of the day clamp to midnight at the end.
    q_item.key.tod          = (in_time_of_day > DAY_END) ? DAY_END : in_time_of_day;
    q_item.key.color.red    = in_key_red;
    q_item.key.color.green  = in_key_green;
    q_item.key.color.blue   = in_key_blue;
    q_item.key.band_mod     = in_key_band_mod;
    q_item.key.band.red     = in_key_band_red;
    q_item.key.band.green   = in_key_band_green;
    q_item.key.band.blue    = in_key_band_blue;
  end

endmodule

`default_nettype wire

/* hw/rtl/kci_back.sv */
// ----------------------------------------------------------------------------
// kci_back: keyframe table, segment search and interpolation
// Appends keyframes, scans for the bracketing segment, divides for the phase
// and blends the seven channels one at a time through a shared lerp unit.
// ----------------------------------------------------------------------------
`default_nettype none

module kci_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kci_pkg::item_t                head,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic [kci_pkg::SCALE_W-1:0]   band_scale,
  output logic                               out_valid,
  output logic [kci_pkg::STAT_W-1:0]         out_status,
  output logic [kci_pkg::COL_W-1:0]          out_red,
  output logic [kci_pkg::COL_W-1:0]          out_green,
  output logic [kci_pkg::COL_W-1:0]          out_blue,
  output logic [kci_pkg::BMOD_W-1:0]         out_band_mod,
  output logic [kci_pkg::COL_W-1:0]          out_band_red,
  output logic [kci_pkg::COL_W-1:0]          out_band_green,
  output logic [kci_pkg::COL_W-1:0]          out_band_blue
);
  import kci_pkg::*;

  key_entry_t          mem [MAX_KEYS];
  key_entry_t          rd_data_r;
  logic                mem_we;

  back_state_t         state_r, state_nxt;
  item_t               item_r, item_nxt;
  logic [KEY_CW-1:0]   cnt_r, cnt_nxt;
  logic [KEY_CW-1:0]   idx_r, idx_nxt;
  key_entry_t          prev_r, prev_nxt;
  key_entry_t          cur_r, cur_nxt;
  logic [TIME_W-1:0]   len_r, len_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [PH_W-1:0]     ph_r, ph_nxt;
  logic [3:0]          div_cnt_r, div_cnt_nxt;
  logic [2:0]          ch_r, ch_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;

  logic                valid_r, valid_nxt;
  status_t             status_r, status_nxt;
  rgb_t                col_r, col_nxt;
  logic [BMOD_W-1:0]   bmod_r, bmod_nxt;
  rgb_t                band_r, band_nxt;

  logic [COL_W-1:0]    a_sel, b_sel;
  logic [SUM_W-1:0]    lerp_sum;
  logic [SUM_W-1:0]    sum_rnd;
  logic [COL_W-1:0]    chan_val;
  logic [PROD_W-1:0]   prod_rnd;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   seg_len;
  logic [TIME_W:0]     rem2;
  logic [KEY_CW-1:0]   last_idx;

  assign last_idx = cnt_r - KEY_CW'(1);

  // Channel select for the shared lerp unit: color, band color, band modifier.
  always_comb begin
    case (ch_r)
      3'd0:    begin a_sel = prev_r.color.red;   b_sel = cur_r.color.red;   end
      3'd1:    begin a_sel = prev_r.color.green; b_sel = cur_r.color.green; end
      3'd2:    begin a_sel = prev_r.color.blue;  b_sel = cur_r.color.blue;  end
      3'd3:    begin a_sel = prev_r.band.red;    b_sel = cur_r.band.red;    end
      3'd4:    begin a_sel = prev_r.band.green;  b_sel = cur_r.band.green;  end
      3'd5:    begin a_sel = prev_r.band.blue;   b_sel = cur_r.band.blue;   end
      default: begin
        a_sel = COL_W'(prev_r.band_mod);
        b_sel = COL_W'(cur_r.band_mod);
      end
    endcase
  end

  assign lerp_sum = SUM_W'(a_sel) * SUM_W'(ONE_Q12 - ph_r) + SUM_W'(b_sel) * SUM_W'(ph_r);
  assign sum_rnd  = sum_r + SUM_W'(2048);
  assign chan_val = sum_rnd[COL_W+11:12];
  assign prod_rnd = prod_r + PROD_W'(1 << 19);
  assign diff     = item_r.key.tod - prev_r.tod;
  assign seg_len  = cur_r.tod - prev_r.tod;
  assign rem2     = {rem_r, 1'b0};

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    ph_nxt      = ph_r;
    div_cnt_nxt = div_cnt_r;
    ch_nxt      = ch_r;
    sum_nxt     = sum_r;
    prod_nxt    = prod_r;
    valid_nxt   = 1'b0;
    status_nxt  = status_r;
    col_nxt     = col_r;
    bmod_nxt    = bmod_r;
    band_nxt    = band_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          item_nxt  = head;
          state_nxt = BK_DISPATCH;
        end
      end
      BK_DISPATCH: begin
        if (item_r.func == FUNC_APPEND) begin
          valid_nxt = 1'b1;
          col_nxt   = '0;
          state_nxt = BK_IDLE;
          if (cnt_r >= KEY_CW'(MAX_KEYS)) begin
            status_nxt = STAT_FULL;
          end else begin
            status_nxt = STAT_OK;
            mem_we     = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end else if (cnt_r == '0) begin
          valid_nxt  = 1'b1;
          status_nxt = STAT_EMPTY;
          col_nxt    = '{ONE_Q12, ONE_Q12, ONE_Q12};
          state_nxt  = BK_IDLE;
        end else if (cnt_r == KEY_CW'(1)) begin
          idx_nxt   = '0;
          state_nxt = BK_SGL_W;
        end else begin
          idx_nxt   = '0;
          state_nxt = BK_CHK0_W;
        end
      end
      BK_SGL_W: state_nxt = BK_SGL;
      BK_SGL: begin
        valid_nxt  = 1'b1;
        status_nxt = STAT_SINGLE;
        col_nxt    = rd_data_r.color;
        state_nxt  = BK_IDLE;
      end
      BK_CHK0_W: state_nxt = BK_CHK0;
      BK_CHK0: begin
        prev_nxt  = rd_data_r;
        idx_nxt   = last_idx;
        state_nxt = BK_CHKN_W;
      end
      BK_CHKN_W: state_nxt = BK_CHKN;
      BK_CHKN: begin
        if (prev_r.tod != '0 || rd_data_r.tod != DAY_END) begin
          valid_nxt  = 1'b1;
          status_nxt = STAT_BAD_ENDS;
          col_nxt    = '{ONE_Q12, ONE_Q12, ONE_Q12};
          bmod_nxt   = BMOD_RESET;
          band_nxt   = '{ONE_Q12, ONE_Q12, ONE_Q12};
          state_nxt  = BK_IDLE;
        end else begin
          idx_nxt   = KEY_CW'(1);
          state_nxt = BK_SCAN_W;
        end
      end
      BK_SCAN_W: state_nxt = BK_SCAN;
      BK_SCAN: begin
        if (item_r.key.tod >= prev_r.tod && item_r.key.tod <= rd_data_r.tod) begin
          cur_nxt   = rd_data_r;
          state_nxt = BK_DIV_INIT;
        end else if (idx_r == last_idx) begin
          valid_nxt  = 1'b1;
          status_nxt = STAT_NO_SEG;
          col_nxt    = '0;
          state_nxt  = BK_IDLE;
        end else begin
          prev_nxt  = rd_data_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = BK_SCAN_W;
        end
      end
      BK_DIV_INIT: begin
        len_nxt = (seg_len == '0) ? TIME_W'(1) : seg_len;
        ch_nxt  = '0;
        // The offset never exceeds the length; equal and nonzero means a phase of one.
        if (seg_len != '0 && diff >= seg_len) begin
          ph_nxt    = ONE_Q12;
          state_nxt = BK_LERP;
        end else begin
          ph_nxt      = '0;
          rem_nxt     = diff;
          div_cnt_nxt = 4'd11;
          state_nxt   = BK_DIV;
        end
      end
      BK_DIV: begin
        if (rem2 >= {1'b0, len_r}) begin
          rem_nxt = TIME_W'(rem2 - {1'b0, len_r});
          ph_nxt  = {ph_r[PH_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[TIME_W-1:0];
          ph_nxt  = {ph_r[PH_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = BK_LERP;
        end
      end
      BK_LERP: begin
        sum_nxt   = lerp_sum;
        state_nxt = BK_STORE;
      end
      BK_STORE: begin
        ch_nxt    = ch_r + 1'b1;
        state_nxt = BK_LERP;
        case (ch_r)
          3'd0:    col_nxt.red    = chan_val;
          3'd1:    col_nxt.green  = chan_val;
          3'd2:    col_nxt.blue   = chan_val;
          3'd3:    band_nxt.red   = chan_val;
          3'd4:    band_nxt.green = chan_val;
          3'd5:    band_nxt.blue  = chan_val;
          default: begin
            prod_nxt  = PROD_W'(sum_r[22:0]) * PROD_W'(band_scale);
            state_nxt = BK_MODFIN;
          end
        endcase
      end
      BK_MODFIN: begin
        bmod_nxt   = (prod_rnd[PROD_W-1:20] > 15'(BMOD_MAX)) ?
                     BMOD_MAX : prod_rnd[20+BMOD_W-1:20];
        valid_nxt  = 1'b1;
        status_nxt = STAT_OK;
        state_nxt  = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
      status_r <= STAT_OK;
      bmod_r   <= BMOD_RESET;
      band_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
      bmod_r   <= bmod_nxt;
      band_r   <= band_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    len_r     <= len_nxt;
    rem_r     <= rem_nxt;
    ph_r      <= ph_nxt;
    div_cnt_r <= div_cnt_nxt;
    ch_r      <= ch_nxt;
    sum_r     <= sum_nxt;
    prod_r    <= prod_nxt;
    col_r     <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[KEY_AW-1:0]] <= item_r.key;
    end
    rd_data_r <= mem[idx_r[KEY_AW-1:0]];
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_red        = col_r.red;
  assign out_green      = col_r.green;
  assign out_blue       = col_r.blue;
  assign out_band_mod   = bmod_r;
  assign out_band_red   = band_r.red;
  assign out_band_green = band_r.green;
  assign out_band_blue  = band_r.blue;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KEY_CW'(MAX_KEYS))
    else $error("entry count exceeds table size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cnt_r < KEY_CW'(MAX_KEYS)))
    else $error("keyframe written into a full table");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe held for two cycles");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (rem_r < len_r))
    else $error("divider remainder not below segment length");

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LERP) |-> (ph_r <= ONE_Q12))
    else $error("phase above one");
`endif

endmodule

`default_nettype wire

/* hw/rtl/keyframe_color_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_color_interpolator: piecewise linear keyframe color blending
//
// Channel  Handshake            Payload
// in       start / busy         in_func, in_time_of_day, in_key_*
// out      out_valid (strobe)   out_status, out_red..blue, out_band_*
// cfg      cfg_wr_en            cfg_wr_data (band_scale, Q4.8)
//
// An append is popped from the queue head, dispatched, and its result is
// strobed from a register. A query reads both endpoints, scans the table
// with one memory read per entry, runs a 12-step restoring divider for the
// phase (skipped for a phase of one) and then blends the seven channels in
// the shared lerp unit. Reset is synchronous, active low, and empties the
// table. The front queue holds two transactions; busy rises only when it is
// full. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_color_interpolator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [kci_pkg::TIME_W-1:0]    in_time_of_day,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_red,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_green,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_blue,
  input  wire logic [kci_pkg::MOD_W-1:0]     in_key_band_mod,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_band_red,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_band_green,
  input  wire logic [kci_pkg::COL_W-1:0]     in_key_band_blue,
  output logic                               out_valid,
  output logic [kci_pkg::STAT_W-1:0]         out_status,
  output logic [kci_pkg::COL_W-1:0]          out_red,
  output logic [kci_pkg::COL_W-1:0]          out_green,
  output logic [kci_pkg::COL_W-1:0]          out_blue,
  output logic [kci_pkg::BMOD_W-1:0]         out_band_mod,
  output logic [kci_pkg::COL_W-1:0]          out_band_red,
  output logic [kci_pkg::COL_W-1:0]          out_band_green,
  output logic [kci_pkg::COL_W-1:0]          out_band_blue,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kci_pkg::SCALE_W-1:0]   cfg_wr_data
);
  import kci_pkg::*;

  logic [SCALE_W-1:0] band_scale_r;
  logic               q_full, q_push, q_empty, q_pop;
  item_t              q_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      band_scale_r <= cfg_wr_data;
    end
  end

  kci_front u_front (
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_time_of_day    (in_time_of_day),
    .in_key_red        (in_key_red),
    .in_key_green      (in_key_green),
    .in_key_blue       (in_key_blue),
    .in_key_band_mod   (in_key_band_mod),
    .in_key_band_red   (in_key_band_red),
    .in_key_band_green (in_key_band_green),
    .in_key_band_blue  (in_key_band_blue),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_item)
  );

  kci_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  kci_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .band_scale     (band_scale_r),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_band_mod   (out_band_mod),
    .out_band_red   (out_band_red),
    .out_band_green (out_band_green),
    .out_band_blue  (out_band_blue)
  );

endmodule

`default_nettype wire
